@@ hdl/mcm_pkg.sv @@
// ----------------------------------------------------------------------------
// mcm_pkg
// Shared codes and types of the multi-channel mailbox.
// ----------------------------------------------------------------------------
package mcm_pkg;

   localparam logic [2:0] OP_OPEN  = 3'd0;
   localparam logic [2:0] OP_CLOSE = 3'd1;
   localparam logic [2:0] OP_SEND  = 3'd2;
   localparam logic [2:0] OP_RECV  = 3'd3;
   localparam logic [2:0] OP_BCAST = 3'd4;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_NO_CHANNEL  = 2'd1;
   localparam logic [1:0] ST_WOULD_BLOCK = 2'd2;
   localparam logic [1:0] ST_NO_SPACE    = 2'd3;

   localparam logic [4:0] MAX_POP   = 5'd16;
   localparam logic [4:0] BATCH_MAX = 5'd31;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_POP,
      FSM_BCAST
   } fsm_type;

endpackage

@@ hdl/multi_channel_mailbox_top.sv @@
// ----------------------------------------------------------------------------
// multi_channel_mailbox_top
// Bank of bounded per-channel word queues over one shared word memory.
// ----------------------------------------------------------------------------
// A command transfers on a rising edge with start high and busy low. Each
// result shows on the rsp_ ports for one cycle with rsp_strobe high and must
// be taken then; there is no back pressure on the result side.
// Open, close and send: result (if any) in the next cycle, and a
// new command may follow right away.
// Receive: a decode step, then one word memory read per cycle; the n
// popped words show back to back, with busy high while they are read.
// Broadcast: a check of every channel, then a walk over the channels
// one by one through the single memory write port; one result.
// The memory port, one access per cycle, sets the receive and broadcast
// rates.
// Reset clears all channel state at once; the word memory needs no
// clearing since a queue entry is read only after it is written.
// ----------------------------------------------------------------------------
module multi_channel_mailbox_top #(
   parameter int NUM_CHANNELS = 8,
   parameter int QUEUE_DEPTH  = 16,
   parameter int WORD_WIDTH   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_operation,
   input  logic [2:0]  req_channel_id,
   input  logic [31:0] req_word_in,
   input  logic [4:0]  req_queue_limit,
   input  logic [4:0]  req_recv_capacity,
   input  logic        req_batch_end,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_channel_out,
   output logic [31:0] rsp_word_out,
   output logic [4:0]  rsp_accepted_count,
   output logic        rsp_last
);

   localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int DEPTH  = NUM_CHANNELS * QUEUE_DEPTH;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SUM_W  = CNT_W + 1;

   mcm_pkg::fsm_type state_ff, state_in;

   logic [PTR_W-1:0]      head_ff [NUM_CHANNELS];
   logic [PTR_W-1:0]      head_in [NUM_CHANNELS];
   logic [CNT_W-1:0]      fill_ff [NUM_CHANNELS];
   logic [CNT_W-1:0]      fill_in [NUM_CHANNELS];
   logic [CNT_W-1:0]      limit_ff [NUM_CHANNELS];
   logic [CNT_W-1:0]      limit_in [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] open_ff, open_in;
   logic [CH_W:0]         hw_ff, hw_in;
   logic [4:0]            batch_ff, batch_in;
   logic [CH_W-1:0]       pch_ff, pch_in;
   logic [4:0]            rem_ff, rem_in;
   logic [4:0]            num_ff, num_in;
   logic [CH_W-1:0]       bidx_ff, bidx_in;
   logic [WORD_WIDTH-1:0] bword_ff, bword_in;

   logic                  strobe_ff, strobe_in;
   logic [1:0]            status_ff, status_in;
   logic [2:0]            chan_ff, chan_in;
   logic [4:0]            count_ff, count_in;
   logic                  last_ff, last_in;
   logic                  wsel_ff, wsel_in;

   logic [WORD_WIDTH-1:0] mem [DEPTH];
   logic [WORD_WIDTH-1:0] rd_data_ff;
   logic                  mem_we, mem_re;
   logic [AW-1:0]         mem_waddr, mem_raddr;
   logic [WORD_WIDTH-1:0] mem_wdata;

   logic                  accept;
   logic                  id_valid;
   logic [CH_W-1:0]       id_idx;
   logic [CH_W-1:0]       ch_addr;
   logic [PTR_W-1:0]      cur_head;
   logic [CNT_W-1:0]      cur_fill;
   logic                  cur_open;
   logic                  cur_full;
   logic [SUM_W-1:0]      tail_sum;
   logic [PTR_W-1:0]      tail_pos;
   logic [AW-1:0]         push_addr;
   logic [AW-1:0]         pop_addr;
   logic [PTR_W-1:0]      head_next;
   logic                  chan_ok;
   logic [10:0]           cap_sat;
   logic [10:0]           pop_n;
   logic                  recv_go;
   logic                  any_full;
   logic                  any_open;
   logic                  bcast_go;
   logic                  free_found;
   logic [CH_W-1:0]       free_slot;
   logic [CNT_W-1:0]      new_limit;
   logic                  send_acc;
   logic [4:0]            batch_next;

   assign accept   = start && (state_ff == mcm_pkg::FSM_IDLE);
   assign id_valid = 32'(req_channel_id) < NUM_CHANNELS;
   assign id_idx   = CH_W'(req_channel_id);

   always_comb begin
      unique case (state_ff)
         mcm_pkg::FSM_POP:   ch_addr = pch_ff;
         mcm_pkg::FSM_BCAST: ch_addr = bidx_ff;
         default:            ch_addr = id_idx;
      endcase
   end

   assign cur_head = head_ff[ch_addr];
   assign cur_fill = fill_ff[ch_addr];
   assign cur_open = open_ff[ch_addr];
   assign cur_full = cur_fill >= limit_ff[ch_addr];
   assign chan_ok  = id_valid && cur_open;

   always_comb begin
      tail_sum = SUM_W'(cur_head) + SUM_W'(cur_fill);
      if (32'(tail_sum) >= QUEUE_DEPTH) begin
         tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
      end
      tail_pos  = PTR_W'(tail_sum);
      push_addr = AW'(32'(ch_addr) * QUEUE_DEPTH + 32'(tail_pos));
      pop_addr  = AW'(32'(ch_addr) * QUEUE_DEPTH + 32'(cur_head));
      head_next = (32'(cur_head) + 1 == QUEUE_DEPTH) ? '0 : cur_head + PTR_W'(1);
   end

   always_comb begin
      cap_sat = (req_recv_capacity > mcm_pkg::MAX_POP) ? 11'(mcm_pkg::MAX_POP)
                                                       : 11'(req_recv_capacity);
      pop_n   = (11'(cur_fill) < cap_sat) ? 11'(cur_fill) : cap_sat;
      recv_go = chan_ok && (cur_fill != '0) && (cap_sat != '0);
   end

   always_comb begin
      any_full   = 1'b0;
      any_open   = |open_ff;
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (open_ff[i] && (fill_ff[i] >= limit_ff[i])) begin
            any_full = 1'b1;
         end
         if ((32'(i) < 32'(hw_ff)) && !open_ff[i]) begin
            free_found = 1'b1;
            free_slot  = CH_W'(i);
         end
      end
      bcast_go  = !any_full && any_open;
      new_limit = (32'(req_queue_limit) > QUEUE_DEPTH) ? CNT_W'(QUEUE_DEPTH)
                                                       : CNT_W'(req_queue_limit);
      send_acc   = chan_ok && !cur_full;
      batch_next = (send_acc && (batch_ff != mcm_pkg::BATCH_MAX)) ? batch_ff + 5'd1
                                                                   : batch_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mcm_pkg::FSM_IDLE: begin
            if (accept && (req_operation == mcm_pkg::OP_RECV) && recv_go) begin
               state_in = mcm_pkg::FSM_POP;
            end else if (accept && (req_operation == mcm_pkg::OP_BCAST) && bcast_go) begin
               state_in = mcm_pkg::FSM_BCAST;
            end
         end
         mcm_pkg::FSM_POP: begin
            if (rem_ff == 5'd1) begin
               state_in = mcm_pkg::FSM_IDLE;
            end
         end
         mcm_pkg::FSM_BCAST: begin
            if (32'(bidx_ff) == NUM_CHANNELS - 1) begin
               state_in = mcm_pkg::FSM_IDLE;
            end
         end
         default: state_in = mcm_pkg::FSM_IDLE;
      endcase
   end

   always_comb begin
      head_in   = head_ff;
      fill_in   = fill_ff;
      limit_in  = limit_ff;
      open_in   = open_ff;
      hw_in     = hw_ff;
      batch_in  = batch_ff;
      pch_in    = pch_ff;
      rem_in    = rem_ff;
      num_in    = num_ff;
      bidx_in   = bidx_ff;
      bword_in  = bword_ff;
      strobe_in = 1'b0;
      status_in = mcm_pkg::ST_OK;
      chan_in   = '0;
      count_in  = '0;
      last_in   = 1'b1;
      wsel_in   = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = push_addr;
      mem_raddr = pop_addr;
      mem_wdata = WORD_WIDTH'(req_word_in);
      unique case (state_ff)
         mcm_pkg::FSM_IDLE: begin
            if (accept) begin
               case (req_operation)
                  mcm_pkg::OP_OPEN: begin
                     strobe_in = 1'b1;
                     if (free_found || (32'(hw_ff) < NUM_CHANNELS)) begin
                        if (free_found) begin
                           open_in[free_slot]  = 1'b1;
                           limit_in[free_slot] = new_limit;
                           head_in[free_slot]  = '0;
                           fill_in[free_slot]  = '0;
                           chan_in             = 3'(free_slot);
                        end else begin
                           open_in[CH_W'(hw_ff)]  = 1'b1;
                           limit_in[CH_W'(hw_ff)] = new_limit;
                           head_in[CH_W'(hw_ff)]  = '0;
                           fill_in[CH_W'(hw_ff)]  = '0;
                           chan_in                = 3'(hw_ff);
                           hw_in                  = hw_ff + (CH_W+1)'(1);
                        end
                     end else begin
                        status_in = mcm_pkg::ST_NO_SPACE;
                     end
                  end
                  mcm_pkg::OP_CLOSE: begin
                     strobe_in = 1'b1;
                     if (chan_ok) begin
                        open_in[ch_addr] = 1'b0;
                        head_in[ch_addr] = '0;
                        fill_in[ch_addr] = '0;
                     end else begin
                        status_in = mcm_pkg::ST_NO_CHANNEL;
                     end
                  end
                  mcm_pkg::OP_SEND: begin
                     if (send_acc) begin
                        mem_we           = 1'b1;
                        fill_in[ch_addr] = cur_fill + CNT_W'(1);
                     end
                     batch_in = batch_next;
                     if (req_batch_end) begin
                        strobe_in = 1'b1;
                        batch_in  = '0;
                        if (!chan_ok) begin
                           status_in = mcm_pkg::ST_NO_CHANNEL;
                        end else if (batch_next == '0) begin
                           status_in = mcm_pkg::ST_WOULD_BLOCK;
                        end else begin
                           count_in = batch_next;
                        end
                     end
                  end
                  mcm_pkg::OP_RECV: begin
                     pch_in = ch_addr;
                     rem_in = 5'(pop_n);
                     num_in = 5'(pop_n);
                     if (!chan_ok) begin
                        strobe_in = 1'b1;
                        status_in = mcm_pkg::ST_NO_CHANNEL;
                     end else if (cur_fill == '0) begin
                        strobe_in = 1'b1;
                        status_in = mcm_pkg::ST_WOULD_BLOCK;
                     end else if (cap_sat == '0) begin
                        strobe_in = 1'b1;
                     end
                  end
                  mcm_pkg::OP_BCAST: begin
                     bidx_in  = '0;
                     bword_in = WORD_WIDTH'(req_word_in);
                     if (any_full) begin
                        strobe_in = 1'b1;
                        status_in = mcm_pkg::ST_WOULD_BLOCK;
                     end else if (!any_open) begin
                        strobe_in = 1'b1;
                        status_in = mcm_pkg::ST_NO_CHANNEL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         mcm_pkg::FSM_POP: begin
            mem_re           = 1'b1;
            head_in[ch_addr] = head_next;
            fill_in[ch_addr] = cur_fill - CNT_W'(1);
            rem_in           = rem_ff - 5'd1;
            strobe_in        = 1'b1;
            count_in         = num_ff;
            last_in          = (rem_ff == 5'd1);
            wsel_in          = 1'b1;
         end
         mcm_pkg::FSM_BCAST: begin
            mem_wdata = bword_ff;
            if (cur_open) begin
               mem_we           = 1'b1;
               fill_in[ch_addr] = cur_fill + CNT_W'(1);
            end
            bidx_in = bidx_ff + CH_W'(1);
            if (32'(bidx_ff) == NUM_CHANNELS - 1) begin
               strobe_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mcm_pkg::FSM_IDLE;
         open_ff   <= '0;
         hw_ff     <= '0;
         batch_ff  <= '0;
         strobe_ff <= 1'b0;
         wsel_ff   <= 1'b0;
         rem_ff    <= '0;
         bidx_ff   <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            head_ff[i]  <= '0;
            fill_ff[i]  <= '0;
            limit_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         open_ff   <= open_in;
         hw_ff     <= hw_in;
         batch_ff  <= batch_in;
         strobe_ff <= strobe_in;
         wsel_ff   <= wsel_in;
         rem_ff    <= rem_in;
         bidx_ff   <= bidx_in;
         head_ff   <= head_in;
         fill_ff   <= fill_in;
         limit_ff  <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      pch_ff    <= pch_in;
      num_ff    <= num_in;
      bword_ff  <= bword_in;
      status_ff <= status_in;
      chan_ff   <= chan_in;
      count_ff  <= count_in;
      last_ff   <= last_in;
   end

   assign busy               = state_ff != mcm_pkg::FSM_IDLE;
   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_channel_out    = chan_ff;
   assign rsp_word_out       = wsel_ff ? 32'(rd_data_ff) : '0;
   assign rsp_accepted_count = count_ff;
   assign rsp_last           = last_ff;

endmodule

@@ hdl/mcm_checker.sv @@
// ----------------------------------------------------------------------------
// mcm_checker
// Port-level checks of the multi-channel mailbox.
// ----------------------------------------------------------------------------
module mcm_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [2:0] req_operation,
   input logic       rsp_strobe,
   input logic [1:0] rsp_status,
   input logic       rsp_last
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_strobe && !busy)
      else $error("result or busy right after reset");

   a_open_close_reply: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_operation == mcm_pkg::OP_OPEN ||
                          req_operation == mcm_pkg::OP_CLOSE))
      |=> rsp_strobe && rsp_last)
      else $error("open or close without a single result next cycle");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != mcm_pkg::ST_OK) |-> rsp_last)
      else $error("error result not marked last");

   a_pop_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=> rsp_strobe)
      else $error("gap inside a multi-word receive");

endmodule

bind multi_channel_mailbox_top mcm_checker u_mcm_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_operation (req_operation),
   .rsp_strobe    (rsp_strobe),
   .rsp_status    (rsp_status),
   .rsp_last      (rsp_last)
);

@@ bench/multi_channel_mailbox_top_tb.sv @@
// ----------------------------------------------------------------------------
// multi_channel_mailbox_top_tb
// Self-checking bench for the multi-channel mailbox: directed open, close,
// send, receive and broadcast cases, then random traffic in bursts. A
// predictor of the queue bank computes the expected responses per transfer.
// ----------------------------------------------------------------------------
module multi_channel_mailbox_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NCH = 8;
   localparam int DEPTH = 16;
   localparam int IDLE_LIMIT = 2000;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  chan;
      logic [31:0] word;
      logic [4:0]  count;
      logic        last;
   } rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_operation = '0;
   logic [2:0]  req_channel_id = '0;
   logic [31:0] req_word_in = '0;
   logic [4:0]  req_queue_limit = '0;
   logic [4:0]  req_recv_capacity = '0;
   logic        req_batch_end = 1'b0;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_channel_out;
   logic [31:0] rsp_word_out;
   logic [4:0]  rsp_accepted_count;
   logic        rsp_last;

   rsp_type expected_rsp[$];
   int   error_count = 0;
   int   idle_cycles = 0;
   int   burst_left = 0;

   logic [31:0] mbox_word[NCH][DEPTH];
   int          mbox_head[NCH];
   int          mbox_fill[NCH];
   int          mbox_limit[NCH];
   bit          mbox_open[NCH];
   int          mbox_high_water;
   int          mbox_batch;

   multi_channel_mailbox_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_channel_id(req_channel_id),
      .req_word_in(req_word_in), .req_queue_limit(req_queue_limit),
      .req_recv_capacity(req_recv_capacity), .req_batch_end(req_batch_end),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_channel_out(rsp_channel_out), .rsp_word_out(rsp_word_out),
      .rsp_accepted_count(rsp_accepted_count), .rsp_last(rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   function automatic void push_rsp(logic [1:0] st, logic [2:0] ch, logic [31:0] w,
                                    logic [4:0] cnt, logic lst);
      rsp_type r;
      r.status = st; r.chan = ch; r.word = w; r.count = cnt; r.last = lst;
      expected_rsp.push_back(r);
   endfunction

   function automatic bit mbox_is_open(int id);
      return id < mbox_high_water && mbox_open[id];
   endfunction

   function automatic void mbox_push(int c, logic [31:0] w);
      mbox_word[c][(mbox_head[c] + mbox_fill[c]) % DEPTH] = w;
      mbox_fill[c]++;
   endfunction

   function automatic void mbox_predict(logic [2:0] op, logic [2:0] id, logic [31:0] w,
                                        logic [4:0] qlim, logic [4:0] rcap, logic bend);
      int  slot;
      int  n;
      int  cap;
      bit  found;
      bit  ok;
      bit  any;
      slot = 0; found = 0; any = 0;
      case (op)
         mcm_pkg::OP_OPEN: begin
            for (int i = 0; i < mbox_high_water; i++)
               if (!mbox_open[i]) begin
                  slot = i; found = 1;
               end
            if (!found) begin
               if (mbox_high_water >= NCH) begin
                  push_rsp(mcm_pkg::ST_NO_SPACE, 0, 0, 0, 1);
                  return;
               end
               slot = mbox_high_water;
               mbox_high_water++;
            end
            mbox_open[slot] = 1;
            mbox_limit[slot] = qlim > DEPTH ? DEPTH : qlim;
            mbox_head[slot] = 0;
            mbox_fill[slot] = 0;
            push_rsp(mcm_pkg::ST_OK, slot[2:0], 0, 0, 1);
         end
         mcm_pkg::OP_CLOSE: begin
            if (!mbox_is_open(id)) begin
               push_rsp(mcm_pkg::ST_NO_CHANNEL, 0, 0, 0, 1);
            end else begin
               mbox_open[id] = 0; mbox_head[id] = 0; mbox_fill[id] = 0;
               push_rsp(mcm_pkg::ST_OK, 0, 0, 0, 1);
            end
         end
         mcm_pkg::OP_SEND: begin
            ok = mbox_is_open(id);
            if (ok && mbox_fill[id] < mbox_limit[id]) begin
               mbox_push(id, w);
               if (mbox_batch < mcm_pkg::BATCH_MAX) mbox_batch++;
            end
            if (bend) begin
               if (!ok) push_rsp(mcm_pkg::ST_NO_CHANNEL, 0, 0, 0, 1);
               else if (mbox_batch == 0) push_rsp(mcm_pkg::ST_WOULD_BLOCK, 0, 0, 0, 1);
               else push_rsp(mcm_pkg::ST_OK, 0, 0, mbox_batch[4:0], 1);
               mbox_batch = 0;
            end
         end
         mcm_pkg::OP_RECV: begin
            cap = rcap > mcm_pkg::MAX_POP ? mcm_pkg::MAX_POP : rcap;
            if (!mbox_is_open(id)) begin
               push_rsp(mcm_pkg::ST_NO_CHANNEL, 0, 0, 0, 1);
            end else if (mbox_fill[id] == 0) begin
               push_rsp(mcm_pkg::ST_WOULD_BLOCK, 0, 0, 0, 1);
            end else if (cap == 0) begin
               push_rsp(mcm_pkg::ST_OK, 0, 0, 0, 1);
            end else begin
               n = mbox_fill[id] < cap ? mbox_fill[id] : cap;
               for (int i = 0; i < n; i++) begin
                  push_rsp(mcm_pkg::ST_OK, 0, mbox_word[id][mbox_head[id]], n[4:0],
                           i + 1 == n);
                  mbox_head[id] = (mbox_head[id] + 1) % DEPTH;
                  mbox_fill[id]--;
               end
            end
         end
         mcm_pkg::OP_BCAST: begin
            for (int i = 0; i < mbox_high_water; i++)
               if (mbox_open[i] && mbox_fill[i] >= mbox_limit[i]) begin
                  push_rsp(mcm_pkg::ST_WOULD_BLOCK, 0, 0, 0, 1);
                  return;
               end
            for (int i = 0; i < mbox_high_water; i++)
               if (mbox_open[i]) begin
                  mbox_push(i, w);
                  any = 1;
               end
            push_rsp(any ? mcm_pkg::ST_OK : mcm_pkg::ST_NO_CHANNEL, 0, 0, 0, 1);
         end
         default: ;
      endcase
   endfunction

   // drive one command, hold until it transfers, then maybe insert a gap
   task automatic send_cmd(input logic [2:0] op, input logic [2:0] id,
                           input logic [31:0] w, input logic [4:0] qlim,
                           input logic [4:0] rcap, input logic bend);
      int gap;
      start <= 1'b1;
      req_operation <= op;
      req_channel_id <= id;
      req_word_in <= w;
      req_queue_limit <= qlim;
      req_recv_capacity <= rcap;
      req_batch_end <= bend;
      do @(posedge clock); while (busy);
      mbox_predict(op, id, w, qlim, rcap, bend);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic test_open_close();
      send_cmd(mcm_pkg::OP_CLOSE, 3'd0, 0, 0, 0, 0);
      for (int i = 0; i < NCH; i++)
         send_cmd(mcm_pkg::OP_OPEN, 0, 0, i == 0 ? 5'd31 : 5'd4, 0, 0);
      send_cmd(mcm_pkg::OP_OPEN, 0, 0, 5'd4, 0, 0);
      send_cmd(mcm_pkg::OP_CLOSE, 3'd7, 0, 0, 0, 0);
      send_cmd(mcm_pkg::OP_CLOSE, 3'd2, 0, 0, 0, 0);
      send_cmd(mcm_pkg::OP_OPEN, 0, 0, 5'd0, 0, 0);
   endtask

   task automatic test_send_receive();
      send_cmd(mcm_pkg::OP_SEND, 3'd0, 32'hFFFF_FFFF, 0, 0, 0);
      send_cmd(mcm_pkg::OP_SEND, 3'd0, 32'h0000_0000, 0, 0, 1);
      send_cmd(mcm_pkg::OP_SEND, 3'd2, 32'h1234_5678, 0, 0, 1);
      send_cmd(mcm_pkg::OP_SEND, 3'd7, 32'hA5A5_5A5A, 0, 0, 1);
      send_cmd(mcm_pkg::OP_RECV, 3'd0, 0, 0, 5'd0, 0);
      send_cmd(mcm_pkg::OP_RECV, 3'd0, 0, 0, 5'd31, 0);
      send_cmd(mcm_pkg::OP_RECV, 3'd0, 0, 0, 5'd1, 0);
   endtask

   task automatic test_broadcast_and_ignored();
      send_cmd(mcm_pkg::OP_BCAST, 0, 32'hDEAD_BEEF, 0, 0, 0);
      send_cmd(3'd5, 3'd1, 0, 0, 0, 1);
      send_cmd(3'd7, 3'd7, 32'hFFFF_FFFF, 5'd31, 5'd31, 1);
      for (int i = 0; i < NCH; i++) send_cmd(mcm_pkg::OP_CLOSE, i[2:0], 0, 0, 0, 0);
      send_cmd(mcm_pkg::OP_BCAST, 0, 32'h5555_AAAA, 0, 0, 0);
   endtask

   task automatic test_random(input int count);
      logic [2:0] op;
      logic [2:0] id;
      int         pick;
      int         len;
      int         sent;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         id = 3'($urandom_range(0, 7));
         if (pick < 10) begin
            op = mcm_pkg::OP_OPEN;
         end else if (pick < 16) begin
            op = mcm_pkg::OP_CLOSE;
         end else if (pick < 50) begin
            op = mcm_pkg::OP_SEND;
         end else if (pick < 82) begin
            op = mcm_pkg::OP_RECV;
         end else if (pick < 92) begin
            op = mcm_pkg::OP_BCAST;
         end else begin
            op = 3'($urandom_range(0, 7));
         end
         if (op == mcm_pkg::OP_SEND) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 4);
            for (int k = 0; k < len; k++) begin
               if (len > 10) id = 3'($urandom_range(0, 7));
               send_cmd(mcm_pkg::OP_SEND, id, $urandom, 5'($urandom), 5'($urandom),
                        k == len - 1);
               sent++;
            end
         end else begin
            send_cmd(op, id, $urandom,
                     5'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 16)),
                     5'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 16)),
                     1'($urandom));
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_strobe) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("response with nothing expected");
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_status !== e.status)
               report_mismatch($sformatf("status %0d exp %0d", rsp_status, e.status));
            if (rsp_channel_out !== e.chan)
               report_mismatch($sformatf("channel %0d exp %0d", rsp_channel_out, e.chan));
            if (rsp_word_out !== e.word)
               report_mismatch($sformatf("word %h exp %h", rsp_word_out, e.word));
            if (rsp_accepted_count !== e.count)
               report_mismatch($sformatf("count %0d exp %0d", rsp_accepted_count, e.count));
            if (rsp_last !== e.last)
               report_mismatch($sformatf("last %0d exp %0d", rsp_last, e.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      for (int c = 0; c < NCH; c++) begin
         mbox_head[c] = 0; mbox_fill[c] = 0; mbox_limit[c] = 0; mbox_open[c] = 0;
      end
      mbox_high_water = 0;
      mbox_batch = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_open_close();
      test_send_receive();
      test_broadcast_and_ignored();
      test_random(420);
      start <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
